// ===== rtl/u8cp_pkg.sv =====
// constants, tables and code point mapping for the utf-8 to single-byte code page transcoder
package u8cp_pkg;

    localparam int unsigned ROM_DEPTH = 128;

    localparam logic [1:0] PAGE_ASCII    = 2'd0;
    localparam logic [1:0] PAGE_CP1250   = 2'd1;
    localparam logic [1:0] PAGE_ISO88592 = 2'd2;

    localparam logic [15:0] CP_HIGH_BASE = 16'h0080;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       unmapped;
    } map_result_t;

    localparam logic [15:0] CP1250_ROM [ROM_DEPTH] = '{
        16'h0080, 16'h0081, 16'h201A, 16'h0083, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h0088, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0098, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A,
        16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
        16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    localparam logic [15:0] ISO88592_ROM [ROM_DEPTH] = '{
        16'h0080, 16'h0081, 16'h0082, 16'h0083, 16'h0084, 16'h0085, 16'h0086, 16'h0087,
        16'h0088, 16'h0089, 16'h008A, 16'h008B, 16'h008C, 16'h008D, 16'h008E, 16'h008F,
        16'h0090, 16'h0091, 16'h0092, 16'h0093, 16'h0094, 16'h0095, 16'h0096, 16'h0097,
        16'h0098, 16'h0099, 16'h009A, 16'h009B, 16'h009C, 16'h009D, 16'h009E, 16'h009F,
        16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
        16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
        16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
        16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    // reverse lookup against constant tables, lowest matching entry wins
    function automatic map_result_t map_code_point(input logic [1:0] page,
                                                   input logic [15:0] cp);
        map_result_t res;
        logic        use_rom;
        logic        is_cp1250;
        res.out_byte = cp[7:0];
        res.unmapped = 1'b0;
        use_rom      = 1'b0;
        is_cp1250    = 1'b0;
        unique case (page)
            PAGE_CP1250: begin
                use_rom   = 1'b1;
                is_cp1250 = 1'b1;
            end
            PAGE_ISO88592: begin
                use_rom = 1'b1;
            end
            default: begin
                use_rom = 1'b0;
            end
        endcase
        if (use_rom && (cp > CP_HIGH_BASE)) begin
            res.unmapped = 1'b1;
            for (int k = ROM_DEPTH - 1; k >= 0; k--) begin
                if ((is_cp1250 ? CP1250_ROM[k] : ISO88592_ROM[k]) == cp) begin
                    res.out_byte = {1'b1, 7'(k)};
                    res.unmapped = 1'b0;
                end
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/utf8_to_single_byte_codepage.sv =====
// top level of the utf-8 to single-byte code page transcoder
// Takes one UTF-8 byte per transfer and emits one byte per decoded character in the
// page held by the code page register (0 ascii truncate, 1 cp1250, 2 iso-8859-2, 3 as 0).
// Lead and inner bytes of a multi-byte sequence give no output; the byte that completes
// it gives one, with m_tuser high when a code point above 0x80 has no entry in the
// selected page and its low byte was sent instead. Stray continuation bytes and four-byte
// leads are passed through raw. One byte is taken every cycle while the skid register is
// empty: decode and the constant-table reverse lookup sit between the input and the
// result register, and a one-entry skid register keeps s_tready up while a result waits.
// Write the code page only while no transfer is in flight.
module utf8_to_single_byte_codepage
    import u8cp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,     // code_page

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tuser        // [0] unmapped
);

    logic [1:0]  code_page_reg;
    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic [15:0] code_point_acc_reg, code_point_acc_next;

    logic        out_valid_reg, out_valid_next;
    map_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    map_result_t skid_data_reg, skid_data_next;

    logic        in_fire;
    logic        produce;
    logic        raw;
    logic [15:0] cp;
    logic [15:0] part;
    map_result_t mapped;
    map_result_t res;
    logic        push;
    logic        pop;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.out_byte;
    assign m_tuser  = out_data_reg.unmapped;

    // utf-8 decode
    always_comb begin
        bytes_pending_next  = bytes_pending_reg;
        code_point_acc_next = code_point_acc_reg;
        produce             = 1'b0;
        raw                 = 1'b0;
        cp                  = {8'd0, s_tdata};
        part = (bytes_pending_reg == 2'd2) ? {4'd0, s_tdata[5:0], 6'd0}
                                           : {10'd0, s_tdata[5:0]};
        if (bytes_pending_reg != 2'd0) begin
            code_point_acc_next = code_point_acc_reg + part;
            bytes_pending_next  = bytes_pending_reg - 2'd1;
            produce             = (bytes_pending_reg == 2'd1);
            cp                  = code_point_acc_next;
        end else if (!s_tdata[7]) begin
            produce = 1'b1;
        end else if (s_tdata[7:5] == 3'b110) begin
            code_point_acc_next = {4'd0, s_tdata[5:0], 6'd0};
            bytes_pending_next  = 2'd1;
        end else if (s_tdata[7:4] == 4'b1110) begin
            code_point_acc_next = {s_tdata[3:0], 12'd0};
            bytes_pending_next  = 2'd2;
        end else begin
            produce = 1'b1;
            raw     = 1'b1;
        end
    end

    assign mapped = map_code_point(code_page_reg, cp);

    always_comb begin
        res = mapped;
        if (raw) begin
            res.out_byte = s_tdata;
            res.unmapped = 1'b0;
        end
    end

    assign push = in_fire && produce;
    assign pop  = out_valid_reg && m_tready;

    // result register and skid register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = res;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_page_reg      <= PAGE_ASCII;
            bytes_pending_reg  <= 2'd0;
            code_point_acc_reg <= 16'd0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                code_page_reg <= cfg_wdata;
            end
            if (in_fire) begin
                bytes_pending_reg  <= bytes_pending_next;
                code_point_acc_reg <= code_point_acc_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
